@@ rtl/core/tsrb_pkg.sv @@
// shared types and constants for the timestamped ring buffer with nearest-time lookup
// no dependencies; used by tsrb_ctrl, tsrb_datapath and the top level
package tsrb_pkg;

	// operation codes carried in the kind field
	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_NOP    = 2'd3;

	localparam logic [15:0] WINDOW_RESET = 16'd100;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] push_time;
		logic [31:0]        push_data;
		logic signed [31:0] query_time;
	} tsrb_in_t;

	typedef struct packed {
		logic               result_valid;
		logic signed [31:0] sample_time;
		logic [31:0]        sample_data;
		logic               within_window;
	} tsrb_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_NOP,
		ST_POP_RD,
		ST_POP_CAP,
		ST_SCAN,
		ST_FB_HEAD,
		ST_FB_NEWEST,
		ST_FB_CAP,
		ST_FB_SEL,
		ST_EMIT
	} tsrb_state_t;

	// read address source
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_NEWEST,
		RD_SCAN
	} tsrb_rd_sel_t;

	// result source
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_POP,
		RES_MATCH,
		RES_NEAR
	} tsrb_res_sel_t;

	typedef struct packed {
		logic          latch;
		logic          push_write;
		logic          head_advance;
		tsrb_rd_sel_t  rd_sel;
		logic          scan_step;
		logic          cap_head;
		logic          cap_newest;
		logic          res_load;
		tsrb_res_sel_t res_sel;
		logic          out_load;
	} tsrb_cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} tsrb_sts_t;

endpackage

@@ rtl/core/timestamped_ring_buffer_nearest_lookup.sv @@
// top level of the timestamped ring buffer with nearest-time lookup
// instantiates tsrb_ctrl and tsrb_datapath; uses tsrb_pkg types
//
// usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one operation per transfer:
//   push a sample at the tail, pop the oldest, look up a query time, or no-op.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one item per command;
//   push and no-op answer with an all-zero item (result_valid low). The user must
//   write window_we/window_wdata (match window, ms) only while idle, unchecked.
// sequencing, one command at a time through the state machine:
//   push / no-op: push writes the sample, both load the zero result, then emit
//   pop: registered memory read of the head entry, then capture and head advance
//   lookup: scan from the head through the registered read until an entry lies in
//   the window; with no match, the scan end, the two end reads and the closest
//   pick follow; the single memory read port takes these reads in turn
// the next command can be taken in the cycle after the result is loaded for output
// reset: head and tail go to zero, window to 100 ms; sample memory is not
//   cleared, so no clearing pass is needed
// receiver stall: the result sits in the output register; a new command can
//   still be taken and worked until its own result waits for that register
module timestamped_ring_buffer_nearest_lookup #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tsrb_pkg::tsrb_in_t  cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tsrb_pkg::tsrb_out_t rsp,
	input  logic                window_we,
	input  logic [15:0]         window_wdata
);

	// payload bits beyond the 32-bit port can never be nonzero, so keep at most 32
	localparam int STORE_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

	tsrb_pkg::tsrb_cmd_t ctl;
	tsrb_pkg::tsrb_sts_t sts;

	// sequencer
	tsrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.kind      (cmd.kind),
		.sts       (sts),
		.ctl       (ctl)
	);

	// storage, compare and output register
	tsrb_datapath #(
		.DEPTH   (DEPTH),
		.STORE_W (STORE_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.window_we    (window_we),
		.window_wdata (window_wdata),
		.ctl          (ctl),
		.sts          (sts),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

endmodule

@@ rtl/core/tsrb_datapath.sv @@
// datapath of the ring buffer: sample memory, head/tail pointers, scan compare,
// end fallback distances, result and output registers; driven by tsrb_ctrl, uses tsrb_pkg
module tsrb_datapath #(
	parameter int DEPTH   = 16,
	parameter int STORE_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tsrb_pkg::tsrb_in_t  cmd,
	input  logic              window_we,
	input  logic [15:0]       window_wdata,
	input  tsrb_pkg::tsrb_cmd_t ctl,
	output tsrb_pkg::tsrb_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tsrb_pkg::tsrb_out_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic signed [31:0] time_mem [DEPTH];
	logic [STORE_W-1:0] data_mem [DEPTH];

	logic [AW-1:0] head_q, tail_q, scan_idx_q;
	logic [AW-1:0] newest, raddr;
	logic          pend_s1;
	logic [15:0]   window_q;

	logic signed [31:0] push_time_q, query_time_q;
	logic [31:0]        push_data_q;
	logic signed [33:0] lo_q, hi_q;

	logic signed [31:0] rd_time_s1;
	logic [STORE_W-1:0] rd_data_s1;
	logic signed [33:0] rd_ext;

	logic signed [32:0] d_pos, d_neg;
	logic [32:0]        gap_abs;

	logic signed [31:0] a_time_q, b_time_q;
	logic [STORE_W-1:0] a_data_q, b_data_q;
	logic [32:0]        a_dist_q, b_dist_q;

	tsrb_pkg::tsrb_out_t res_q, res_d;
	tsrb_pkg::tsrb_out_t rsp_q;
	logic                rsp_valid_q;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	assign newest = (tail_q == '0) ? LAST : tail_q - 1'b1;

	always_comb begin
		unique case (ctl.rd_sel)
			tsrb_pkg::RD_HEAD:   raddr = head_q;
			tsrb_pkg::RD_NEWEST: raddr = newest;
			tsrb_pkg::RD_SCAN:   raddr = scan_idx_q;
			default:             raddr = head_q;
		endcase
	end

	// sample memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.push_write) begin
			time_mem[tail_q] <= push_time_q;
			data_mem[tail_q] <= STORE_W'(push_data_q);
		end
		rd_time_s1 <= time_mem[raddr];
		rd_data_s1 <= data_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			scan_idx_q  <= '0;
			pend_s1     <= 1'b0;
			window_q    <= tsrb_pkg::WINDOW_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (window_we) window_q <= window_wdata;
			if (ctl.push_write) tail_q <= next_idx(tail_q);
			if (ctl.head_advance) head_q <= next_idx(head_q);
			pend_s1 <= ctl.scan_step && (scan_idx_q != tail_q);
			if (ctl.latch) begin
				scan_idx_q <= head_q;
			end else if (ctl.scan_step && (scan_idx_q != tail_q)) begin
				scan_idx_q <= next_idx(scan_idx_q);
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item capture and window bounds
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			push_time_q  <= cmd.push_time;
			push_data_q  <= cmd.push_data;
			query_time_q <= cmd.query_time;
			lo_q <= 34'(cmd.query_time) - $signed({18'b0, window_q});
			hi_q <= 34'(cmd.query_time) + $signed({18'b0, window_q});
		end
	end

	assign rd_ext = 34'(rd_time_s1);

	assign sts.scan_hit  = pend_s1 && (rd_ext >= lo_q) && (rd_ext <= hi_q);
	assign sts.scan_done = !pend_s1 && (scan_idx_q == tail_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// distance to query time, both differences side by side
	assign d_pos   = 33'(rd_time_s1) - 33'(query_time_q);
	assign d_neg   = 33'(query_time_q) - 33'(rd_time_s1);
	assign gap_abs = d_pos[32] ? d_neg : d_pos;

	always_ff @(posedge clk) begin
		if (ctl.cap_head) begin
			a_time_q <= rd_time_s1;
			a_data_q <= rd_data_s1;
			a_dist_q <= gap_abs;
		end
		if (ctl.cap_newest) begin
			b_time_q <= rd_time_s1;
			b_data_q <= rd_data_s1;
			b_dist_q <= gap_abs;
		end
	end

	always_comb begin
		res_d = '0;
		unique case (ctl.res_sel)
			tsrb_pkg::RES_ZERO: res_d = '0;
			tsrb_pkg::RES_POP: begin
				res_d.result_valid = 1'b1;
				res_d.sample_time  = rd_time_s1;
				res_d.sample_data  = 32'(rd_data_s1);
			end
			tsrb_pkg::RES_MATCH: begin
				res_d.result_valid  = 1'b1;
				res_d.sample_time   = rd_time_s1;
				res_d.sample_data   = 32'(rd_data_s1);
				res_d.within_window = 1'b1;
			end
			tsrb_pkg::RES_NEAR: begin
				res_d.result_valid = 1'b1;
				// tie goes to the oldest
				if (a_dist_q <= b_dist_q) begin
					res_d.sample_time = a_time_q;
					res_d.sample_data = 32'(a_data_q);
				end else begin
					res_d.sample_time = b_time_q;
					res_d.sample_data = 32'(b_data_q);
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) res_q <= res_d;
		if (ctl.out_load) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_pend_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(ctl.scan_step && (ctl.rd_sel == tsrb_pkg::RD_SCAN)))
		else $error("scan data valid without a scan read");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push_write && ctl.head_advance))
		else $error("push and pop in the same cycle");

	a_near_after_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.res_load && (ctl.res_sel == tsrb_pkg::RES_NEAR)) |-> $past(ctl.cap_newest))
		else $error("fallback pick before newest entry captured");

endmodule

@@ rtl/core/tsrb_ctrl.sv @@
// ring buffer controller state machine: sequences push, pop, no-op, scan and fallback
// drives tsrb_datapath through command/status structs from tsrb_pkg
module tsrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [1:0]        kind,
	input  tsrb_pkg::tsrb_sts_t sts,
	output tsrb_pkg::tsrb_cmd_t ctl
);

	tsrb_pkg::tsrb_state_t state_q, state_d;
	logic                  accept;

	assign cmd_stall = (state_q != tsrb_pkg::ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		ctl              = '0;
		ctl.rd_sel       = tsrb_pkg::RD_HEAD;
		ctl.res_sel      = tsrb_pkg::RES_ZERO;
		unique case (state_q)
			tsrb_pkg::ST_IDLE: begin
				if (accept) begin
					ctl.latch = 1'b1;
					unique case (kind)
						tsrb_pkg::KIND_PUSH:   state_d = tsrb_pkg::ST_PUSH;
						tsrb_pkg::KIND_POP:    state_d = tsrb_pkg::ST_POP_RD;
						tsrb_pkg::KIND_LOOKUP: state_d = tsrb_pkg::ST_SCAN;
						default:               state_d = tsrb_pkg::ST_NOP;
					endcase
				end
			end
			tsrb_pkg::ST_PUSH: begin
				ctl.push_write = 1'b1;
				ctl.res_load   = 1'b1;
				state_d        = tsrb_pkg::ST_EMIT;
			end
			tsrb_pkg::ST_NOP: begin
				ctl.res_load = 1'b1;
				state_d      = tsrb_pkg::ST_EMIT;
			end
			tsrb_pkg::ST_POP_RD: begin
				state_d = tsrb_pkg::ST_POP_CAP;
			end
			tsrb_pkg::ST_POP_CAP: begin
				ctl.res_sel      = tsrb_pkg::RES_POP;
				ctl.res_load     = 1'b1;
				ctl.head_advance = 1'b1;
				state_d          = tsrb_pkg::ST_EMIT;
			end
			tsrb_pkg::ST_SCAN: begin
				ctl.rd_sel = tsrb_pkg::RD_SCAN;
				priority if (sts.scan_hit) begin
					ctl.res_sel  = tsrb_pkg::RES_MATCH;
					ctl.res_load = 1'b1;
					state_d      = tsrb_pkg::ST_EMIT;
				end else if (sts.scan_done) begin
					state_d = tsrb_pkg::ST_FB_HEAD;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			tsrb_pkg::ST_FB_HEAD: begin
				state_d = tsrb_pkg::ST_FB_NEWEST;
			end
			tsrb_pkg::ST_FB_NEWEST: begin
				ctl.rd_sel   = tsrb_pkg::RD_NEWEST;
				ctl.cap_head = 1'b1;
				state_d      = tsrb_pkg::ST_FB_CAP;
			end
			tsrb_pkg::ST_FB_CAP: begin
				ctl.rd_sel     = tsrb_pkg::RD_NEWEST;
				ctl.cap_newest = 1'b1;
				state_d        = tsrb_pkg::ST_FB_SEL;
			end
			tsrb_pkg::ST_FB_SEL: begin
				ctl.res_sel  = tsrb_pkg::RES_NEAR;
				ctl.res_load = 1'b1;
				state_d      = tsrb_pkg::ST_EMIT;
			end
			tsrb_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = tsrb_pkg::ST_IDLE;
				end
			end
			default: state_d = tsrb_pkg::ST_IDLE;
		endcase
	end

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("accepted transfer did not start work");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> sts.out_free)
		else $error("output register overwritten while held");

	a_res_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |=> (state_q == tsrb_pkg::ST_EMIT))
		else $error("result loaded outside the emit path");

endmodule
